// ===== hw/rtl/mec_pkg.sv =====
// ---------------------------------------------------------------------------
// mec_pkg
// Shared types and constants for the escape-time counter.
// ---------------------------------------------------------------------------
package mec_pkg;

  localparam int IDX_W = 10;
  localparam int CNT_W = 12;
  localparam int CFG_W = 32;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_RE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_IM = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_RE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_IM   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER  = 3'd4;

  typedef struct packed {
    logic [IDX_W-1:0] col;
    logic [IDX_W-1:0] row;
    logic [31:0]      c_re;
    logic [31:0]      c_im;
    logic             c_ovf;
  } mec_job_t;

endpackage

// ===== hw/rtl/mec_front.sv =====
// ---------------------------------------------------------------------------
// mec_front
// Accepts pixels and forms c over two stages (multiply, then add and range
// check). Output is a registered job handshake.
// ---------------------------------------------------------------------------
module mec_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [9:0]           pixel_col,
  input  logic [9:0]           pixel_row,
  input  logic signed [31:0]   origin_re,
  input  logic signed [31:0]   origin_im,
  input  logic [30:0]          step_re,
  input  logic [30:0]          step_im,
  output logic                 job_valid,
  input  logic                 job_ready,
  output mec_pkg::mec_job_t    job
);
  import mec_pkg::*;

  logic             s1_valid;
  logic [IDX_W-1:0] s1_col;
  logic [IDX_W-1:0] s1_row;
  logic [40:0]      s1_pr;
  logic [40:0]      s1_pi;
  logic             s1_ready;
  logic signed [42:0] sum_re;
  logic signed [42:0] sum_im;

  assign s1_ready = !job_valid || job_ready;
  assign in_ready = !s1_valid || s1_ready;

  assign sum_re = 43'(origin_re) + $signed({2'b00, s1_pr});
  assign sum_im = 43'(origin_im) - $signed({2'b00, s1_pi});

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      job_valid <= 1'b0;
    end else begin
      if (in_ready) s1_valid <= in_valid;
      if (s1_ready) job_valid <= s1_valid;
    end
    if (in_valid && in_ready) begin
      s1_col <= pixel_col;
      s1_row <= pixel_row;
      s1_pr  <= 41'(pixel_col) * 41'(step_re);
      s1_pi  <= 41'(pixel_row) * 41'(step_im);
    end
    if (s1_valid && s1_ready) begin
      job.col   <= s1_col;
      job.row   <= s1_row;
      job.c_re  <= sum_re[31:0];
      job.c_im  <= sum_im[31:0];
      job.c_ovf <= (sum_re > 43'sd2147483647) || (sum_re < -43'sd2147483648) ||
                   (sum_im > 43'sd2147483647) || (sum_im < -43'sd2147483648);
    end
  end

endmodule

// ===== hw/rtl/mec_queue.sv =====
// ---------------------------------------------------------------------------
// mec_queue
// Small FIFO of jobs between the front and the iteration engine.
// ---------------------------------------------------------------------------
module mec_queue #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_valid,
  output logic              wr_ready,
  input  mec_pkg::mec_job_t wr_data,
  output logic              rd_valid,
  input  logic              rd_ready,
  output mec_pkg::mec_job_t rd_data
);
  import mec_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  mec_job_t        mem [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [AW:0]     fill;
  logic            do_wr;
  logic            do_rd;

  assign wr_ready = fill != (AW+1)'(DEPTH);
  assign rd_valid = fill != '0;
  assign rd_data  = mem[rd_ptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_wr) wr_ptr <= (wr_ptr == AW'(DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      if (do_rd) rd_ptr <= (rd_ptr == AW'(DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      fill <= fill + (AW+1)'(do_wr) - (AW+1)'(do_rd);
    end
    if (do_wr) mem[wr_ptr] <= wr_data;
  end

endmodule

// ===== hw/rtl/mec_engine.sv =====
// ---------------------------------------------------------------------------
// mec_engine
// Iterates z = z^2 + c for one job. Each iteration: square stage (three
// 32x32 products), update stage, magnitude square stage, magnitude test.
// ---------------------------------------------------------------------------
module mec_engine #(
  parameter int FRAC_BITS = 28
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 job_valid,
  output logic                 job_ready,
  input  mec_pkg::mec_job_t    job,
  input  logic [11:0]          max_iterations,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [9:0]           out_col,
  output logic [9:0]           out_row,
  output logic [11:0]          escape_count,
  output logic                 inside_set
);
  import mec_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SQ   = 3'd1;
  localparam logic [2:0] ST_UPD  = 3'd2;
  localparam logic [2:0] ST_MAG  = 3'd3;
  localparam logic [2:0] ST_TEST = 3'd4;

  logic [2:0]           state;
  logic [IDX_W-1:0]     col;
  logic [IDX_W-1:0]     row;
  logic signed [31:0]   c_re;
  logic signed [31:0]   c_im;
  logic signed [31:0]   zr;
  logic signed [31:0]   zi;
  logic signed [63:0]   p_rr;
  logic signed [63:0]   p_ii;
  logic signed [63:0]   p_ri;
  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     limit;
  logic signed [64:0]   diff;
  logic signed [64:0]   nr;
  logic signed [64:0]   ni;
  logic [64:0]          mag;
  logic [64:0]          bound;
  logic                 nr_ok;
  logic                 ni_ok;

  assign job_ready = state == ST_IDLE && !out_valid;
  assign diff  = 65'(p_rr) - 65'(p_ii);
  assign nr    = (diff >>> FRAC_BITS) + 65'(c_re);
  assign ni    = (65'(p_ri) >>> (FRAC_BITS - 1)) + 65'(c_im);
  assign nr_ok = nr >= -65'sd2147483648 && nr <= 65'sd2147483647;
  assign ni_ok = ni >= -65'sd2147483648 && ni <= 65'sd2147483647;
  assign mag   = 65'($unsigned(p_rr)) + 65'($unsigned(p_ii));
  assign bound = 65'(4) << FRAC_BITS;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (job_valid && job_ready) begin
            col   <= job.col;
            row   <= job.row;
            c_re  <= job.c_re;
            c_im  <= job.c_im;
            zr    <= '0;
            zi    <= '0;
            count <= '0;
            limit <= (max_iterations == '0) ? CNT_W'(1) : max_iterations;
            if (job.c_ovf) begin
              out_col      <= job.col;
              out_row      <= job.row;
              escape_count <= '0;
              inside_set   <= 1'b0;
              out_valid    <= 1'b1;
            end else begin
              state <= ST_SQ;
            end
          end
        end
        ST_SQ: begin
          p_rr  <= zr * zr;
          p_ii  <= zi * zi;
          p_ri  <= zr * zi;
          state <= ST_UPD;
        end
        ST_UPD: begin
          if (!nr_ok || !ni_ok) begin
            out_col      <= col;
            out_row      <= row;
            escape_count <= count;
            inside_set   <= 1'b0;
            out_valid    <= 1'b1;
            state        <= ST_IDLE;
          end else begin
            zr    <= nr[31:0];
            zi    <= ni[31:0];
            state <= ST_MAG;
          end
        end
        ST_MAG: begin
          p_rr  <= zr * zr;
          p_ii  <= zi * zi;
          state <= ST_TEST;
        end
        ST_TEST: begin
          if ((mag >> FRAC_BITS) > bound || count == limit - 1'b1) begin
            out_col      <= col;
            out_row      <= row;
            escape_count <= count;
            inside_set   <= !((mag >> FRAC_BITS) > bound);
            out_valid    <= 1'b1;
            state        <= ST_IDLE;
          end else begin
            count <= count + 1'b1;
            state <= ST_SQ;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/mandelbrot_escape_counter.sv =====
// ---------------------------------------------------------------------------
// mandelbrot_escape_counter
// Escape-time count per pixel in signed fixed point.
// ---------------------------------------------------------------------------
// Input channel (in_valid/in_ready) takes a pixel column and row; output
// channel (out_valid/out_ready) returns the column, row, escape count and
// inside flag, one transaction per pixel, in input order.
// Front: two stages form c and flag coordinate overflow; a 4-entry job queue
// feeds the iteration engine, so the front keeps taking pixels while the
// engine works.
// Engine: each iteration runs the square, update, magnitude square and test
// steps; the reset iteration limit is 100. From acceptance, a pixel passes
// the front's two registered stages and the job queue before the engine
// iterates it. The engine takes a new job only after its result has been
// taken, so a stalled receiver holds the engine and then fills the queue.
// Reset clears all handshake state and loads the default view. The user
// must make configuration writes (cfg_we, cfg_index, cfg_data) only while
// idle; the block itself does not enforce this.
// ---------------------------------------------------------------------------
module mandelbrot_escape_counter #(
  parameter int GRID_COLS = 1024,
  parameter int GRID_ROWS = 1024,
  parameter int FRAC_BITS = 28
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [9:0]  pixel_col,
  input  logic [9:0]  pixel_row,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [9:0]  out_col,
  output logic [9:0]  out_row,
  output logic [11:0] escape_count,
  output logic        inside_set
);
  import mec_pkg::*;

  localparam logic [31:0] RST_ORIGIN_RE = 32'(-(64'sd2 <<< FRAC_BITS));
  localparam logic [31:0] RST_ORIGIN_IM = 32'(64'sd1 <<< FRAC_BITS);
  localparam logic [30:0] RST_STEP_RE   = 31'((64'd3 << FRAC_BITS) / GRID_COLS);
  localparam logic [30:0] RST_STEP_IM   = 31'((64'd2 << FRAC_BITS) / GRID_ROWS);

  logic signed [31:0] origin_re;
  logic signed [31:0] origin_im;
  logic [30:0]        step_re;
  logic [30:0]        step_im;
  logic [11:0]        max_iterations;

  logic     fq_valid, fq_ready, qe_valid, qe_ready;
  mec_job_t fq_job, qe_job;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_re      <= RST_ORIGIN_RE;
      origin_im      <= RST_ORIGIN_IM;
      step_re        <= RST_STEP_RE;
      step_im        <= RST_STEP_IM;
      max_iterations <= 12'd100;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ORIGIN_RE: origin_re      <= cfg_data;
        REG_ORIGIN_IM: origin_im      <= cfg_data;
        REG_STEP_RE:   step_re        <= cfg_data[30:0];
        REG_STEP_IM:   step_im        <= cfg_data[30:0];
        REG_MAX_ITER:  max_iterations <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  mec_front u_front (
    .clk, .rst, .in_valid, .in_ready, .pixel_col, .pixel_row,
    .origin_re, .origin_im, .step_re, .step_im,
    .job_valid(fq_valid), .job_ready(fq_ready), .job(fq_job)
  );

  mec_queue #(.DEPTH(4)) u_queue (
    .clk, .rst,
    .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_data(fq_job),
    .rd_valid(qe_valid), .rd_ready(qe_ready), .rd_data(qe_job)
  );

  mec_engine #(.FRAC_BITS(FRAC_BITS)) u_engine (
    .clk, .rst,
    .job_valid(qe_valid), .job_ready(qe_ready), .job(qe_job),
    .max_iterations,
    .out_valid, .out_ready, .out_col, .out_row, .escape_count, .inside_set
  );

endmodule
